// ===== rtl/sta_pkg.sv =====
// shared types, constants and helpers for the sensor threshold alarm
// no dependencies
package sta_pkg;

    localparam int SENSORS_DEF     = 4;
    localparam int TREND_DEPTH_DEF = 24;
    localparam int NOISE_STEP_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int SENS_W = 2;
    localparam int RAW_W  = 13;
    localparam int HOUR_W = 5;
    localparam int SLOT_W = 5;
    localparam int VAL_W  = 12;
    localparam int CNT_W  = 8;
    localparam int QUOT_W = 16;
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 12;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_IDLE   = 2'd3
    } t_mode;

    localparam logic [1:0] COND_NONE = 2'd0;
    localparam logic [1:0] COND_LT   = 2'd1;
    localparam logic [1:0] COND_GT   = 2'd2;
    localparam logic [1:0] COND_RSVD = 2'd3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TRIP0  = 3'd0,
        CFG_TRIP1  = 3'd1,
        CFG_TRIP2  = 3'd2,
        CFG_TRIP3  = 3'd3,
        CFG_COND   = 3'd4,
        CFG_HYST   = 3'd5,
        CFG_CONSEC = 3'd6,
        CFG_MAXATT = 3'd7
    } t_cfg;

    typedef struct packed {
        t_mode               mode;
        logic [SENS_W-1:0]   sensor;
        logic                sensor_ok;
        logic                bad_read;
        logic                zero_val;
        logic [QUOT_W-1:0]   quot;
        logic [HOUR_W-1:0]   hour;
        logic                delivered;
        logic [SLOT_W-1:0]   slot;
    } t_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/sta_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module sta_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sta_front.sv =====
// front end: decodes an input beat and quantizes the reading
// depends on sta_pkg
module sta_front import sta_pkg::*; #(
    parameter int SENSORS     = SENSORS_DEF,
    parameter int NOISE_STEP  = NOISE_STEP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic [1:0]        i_mode,
    input  logic [SENS_W-1:0] i_sensor,
    input  logic [RAW_W-1:0]  i_raw_reading,
    input  logic [HOUR_W-1:0] i_hour,
    input  logic              i_alert_delivered,
    input  logic [SLOT_W-1:0] i_trend_slot,
    output t_item             o_item
);
    localparam int SHIFT   = SAMPLE_BITS + $clog2(NOISE_STEP);
    localparam int RECIP_W = SAMPLE_BITS + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** SHIFT + NOISE_STEP - 1) / NOISE_STEP);
    localparam logic [16:0] MAX_S = 17'((2 ** SAMPLE_BITS) - 1);
    localparam int PROD_W = SAMPLE_BITS + RECIP_W;

    logic                   neg;
    logic [16:0]            mag_x;
    logic [16:0]            sat_x;
    logic [SAMPLE_BITS-1:0] sat;
    logic [PROD_W-1:0]      prod;

    assign neg   = i_raw_reading[RAW_W-1];
    assign mag_x = 17'(i_raw_reading[RAW_W-2:0]);
    assign sat_x = (mag_x > MAX_S) ? MAX_S : mag_x;
    assign sat   = sat_x[SAMPLE_BITS-1:0];
    assign prod  = PROD_W'(sat) * PROD_W'(RECIP);

    always_comb begin
        o_item.mode      = t_mode'(i_mode);
        o_item.sensor    = i_sensor;
        o_item.sensor_ok = 32'(i_sensor) < SENSORS;
        o_item.bad_read  = i_raw_reading == {RAW_W{1'b1}};
        o_item.zero_val  = neg || (sat_x <= 17'(NOISE_STEP));
        o_item.quot      = QUOT_W'(prod >> SHIFT);
        o_item.hour      = i_hour;
        o_item.delivered = i_alert_delivered;
        o_item.slot      = i_trend_slot;
    end
endmodule

// ===== rtl/sta_fifo.sv =====
// two entry queue between front and back
// depends on sta_pkg
module sta_fifo import sta_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_data
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
endmodule

// ===== rtl/sta_back.sv =====
// back end: per sensor state, alarm logic, trend store and result register
// depends on sta_pkg and sta_ram
module sta_back import sta_pkg::*; #(
    parameter int SENSORS     = SENSORS_DEF,
    parameter int TREND_DEPTH = TREND_DEPTH_DEF,
    parameter int NOISE_STEP  = NOISE_STEP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CDAT_W-1:0] i_cfg_data,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_value,
    output logic              o_read_error,
    output logic              o_send_alert,
    output logic              o_alert_armed,
    output logic [CNT_W-1:0]  o_attempt_count,
    output logic [VAL_W-1:0]  o_trend_value
);
    localparam int HW    = $clog2(TREND_DEPTH);
    localparam int DEPTH = SENSORS * TREND_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NS_W  = $clog2(NOISE_STEP + 1);

    logic [VAL_W-1:0] r_trip [4];
    logic [7:0]       r_cond;
    logic [VAL_W-1:0] r_hyst;
    logic [CNT_W-1:0] r_consec;
    logic [CNT_W-1:0] r_maxatt;

    logic [VAL_W-1:0]  r_value [SENSORS], n_value [SENSORS];
    logic              r_err   [SENSORS], n_err   [SENSORS];
    logic [HW-1:0]     r_head  [SENSORS], n_head  [SENSORS];
    logic [HOUR_W-1:0] r_last  [SENSORS], n_last  [SENSORS];
    logic [CNT_W-1:0]  r_on    [SENSORS], n_on    [SENSORS];
    logic [CNT_W-1:0]  r_off   [SENSORS], n_off   [SENSORS];
    logic [1:0]        r_prev  [SENSORS], n_prev  [SENSORS];
    logic              r_armed [SENSORS], n_armed [SENSORS];
    logic [CNT_W-1:0]  r_att   [SENSORS], n_att   [SENSORS];
    logic              r_primed, n_primed;
    logic [DEPTH-1:0]  r_tvld;

    logic              r_ov;
    logic [VAL_W-1:0]  r_o_value;
    logic              r_o_err;
    logic              r_o_sent;
    logic              r_o_armed;
    logic [CNT_W-1:0]  r_o_att;
    logic              r_tsel;
    logic              r_rd_vld;

    logic                    fire;
    logic [SENS_W-1:0]       s;
    logic [QUOT_W+NS_W-1:0]  qprod;
    logic [VAL_W-1:0]        vq;
    logic [1:0]              cond;
    logic [VAL_W-1:0]        val;
    logic [VAL_W-1:0]        trip;
    logic                    hit_on;
    logic                    hit_off;
    logic [CNT_W-1:0]        on_b;
    logic [CNT_W-1:0]        off_b;
    logic [CNT_W-1:0]        ct;
    logic                    arm_n;
    logic [CNT_W-1:0]        att_n;
    logic                    sent;
    logic [HOUR_W-1:0]       last_cmp;
    logic [HW-1:0]           hd_dec;
    logic                    slot_ok;
    logic [HW:0]             rsum;
    logic [HW-1:0]           ridx;
    logic [AW-1:0]           base;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic                    tsel;
    logic [VAL_W-1:0]        rdata;

    assign fire  = i_item_valid && (!r_ov || !i_stall);
    assign o_pop = fire;
    assign s     = i_item.sensor;

    assign qprod = (QUOT_W + NS_W)'(i_item.quot) * (QUOT_W + NS_W)'(NOISE_STEP);
    assign vq    = i_item.zero_val ? '0 : qprod[VAL_W-1:0];

    assign cond = (r_cond[2*s +: 2] == COND_RSVD) ? COND_NONE : r_cond[2*s +: 2];
    assign val  = r_value[s];
    assign trip = r_trip[s];

    always_comb begin
        hit_on  = 1'b0;
        hit_off = 1'b0;
        case (cond)
            COND_LT: begin
                hit_on  = val < trip;
                hit_off = {1'b0, val} >= ({1'b0, trip} + {1'b0, r_hyst});
            end
            COND_GT: begin
                hit_on  = val > trip;
                hit_off = ({1'b0, val} + {1'b0, r_hyst}) <= {1'b0, trip};
            end
            default: begin
                hit_on  = 1'b0;
                hit_off = 1'b0;
            end
        endcase
    end

    assign on_b  = (cond != r_prev[s]) ? '0 : r_on[s];
    assign off_b = (cond != r_prev[s]) ? '0 : r_off[s];
    assign ct    = hit_on ? sat_inc(on_b) : sat_inc(off_b);
    assign arm_n = !i_item.delivered;
    assign att_n = arm_n ? sat_inc(r_att[s]) : '0;

    assign base     = AW'(32'(s) * TREND_DEPTH);
    assign hd_dec   = (r_head[s] == '0) ? HW'(TREND_DEPTH - 1) : r_head[s] - 1'b1;
    assign waddr    = base + AW'(hd_dec);
    assign last_cmp = r_primed ? r_last[s] : i_item.hour;

    assign slot_ok = 32'(i_item.slot) < TREND_DEPTH;
    assign rsum    = {1'b0, r_head[s]} + {1'b0, HW'(i_item.slot)};
    assign ridx    = (32'(rsum) >= TREND_DEPTH) ? HW'(32'(rsum) - TREND_DEPTH) : rsum[HW-1:0];
    assign raddr   = base + AW'(ridx);
    assign tsel    = i_item.sensor_ok && (i_item.mode == MODE_READ) && slot_ok;

    always_comb begin
        n_value  = r_value;
        n_err    = r_err;
        n_head   = r_head;
        n_last   = r_last;
        n_on     = r_on;
        n_off    = r_off;
        n_prev   = r_prev;
        n_armed  = r_armed;
        n_att    = r_att;
        n_primed = r_primed;
        sent     = 1'b0;
        we       = 1'b0;
        if (fire && i_item.sensor_ok) begin
            case (i_item.mode)
                MODE_SAMPLE: begin
                    if (i_item.bad_read) begin
                        n_err[s] = 1'b1;
                    end else begin
                        n_err[s]   = 1'b0;
                        n_value[s] = vq;
                        if (!r_primed) begin
                            for (int i = 0; i < SENSORS; i++) begin
                                n_last[i] = i_item.hour;
                            end
                            n_primed = 1'b1;
                        end
                        if (i_item.hour != last_cmp) begin
                            n_head[s] = hd_dec;
                            n_last[s] = i_item.hour;
                            we        = 1'b1;
                        end
                    end
                end
                MODE_CHECK: begin
                    if (!r_err[s]) begin
                        n_prev[s] = cond;
                        n_on[s]   = on_b;
                        n_off[s]  = off_b;
                        if (hit_on) begin
                            n_on[s]  = sat_inc(on_b);
                            n_off[s] = '0;
                        end else if (hit_off) begin
                            n_on[s]  = '0;
                            n_off[s] = sat_inc(off_b);
                        end
                        if ((hit_on || hit_off) && ct >= r_consec) begin
                            if (hit_off) begin
                                n_armed[s] = 1'b1;
                                n_att[s]   = '0;
                            end else if (r_armed[s]) begin
                                sent       = 1'b1;
                                n_att[s]   = att_n;
                                n_armed[s] = arm_n && !(att_n >= r_maxatt);
                            end
                        end
                    end
                end
                default: begin
                    sent = 1'b0;
                end
            endcase
        end
    end

    sta_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_trend (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (vq),
        .i_re    (fire),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_trip[i] <= '0;
            end
            r_cond   <= '0;
            r_hyst   <= VAL_W'(50);
            r_consec <= CNT_W'(5);
            r_maxatt <= CNT_W'(5);
            for (int i = 0; i < SENSORS; i++) begin
                r_value[i] <= '0;
                r_err[i]   <= 1'b0;
                r_head[i]  <= '0;
                r_last[i]  <= '0;
                r_on[i]    <= '0;
                r_off[i]   <= '0;
                r_prev[i]  <= COND_NONE;
                r_armed[i] <= 1'b1;
                r_att[i]   <= '0;
            end
            r_primed <= 1'b0;
            r_tvld   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg'(i_cfg_idx))
                    CFG_TRIP0:  r_trip[0] <= i_cfg_data;
                    CFG_TRIP1:  r_trip[1] <= i_cfg_data;
                    CFG_TRIP2:  r_trip[2] <= i_cfg_data;
                    CFG_TRIP3:  r_trip[3] <= i_cfg_data;
                    CFG_COND:   r_cond    <= i_cfg_data[7:0];
                    CFG_HYST:   r_hyst    <= i_cfg_data;
                    CFG_CONSEC: r_consec  <= i_cfg_data[CNT_W-1:0];
                    CFG_MAXATT: r_maxatt  <= i_cfg_data[CNT_W-1:0];
                    default:    r_cond    <= r_cond;
                endcase
            end
            r_value  <= n_value;
            r_err    <= n_err;
            r_head   <= n_head;
            r_last   <= n_last;
            r_on     <= n_on;
            r_off    <= n_off;
            r_prev   <= n_prev;
            r_armed  <= n_armed;
            r_att    <= n_att;
            r_primed <= n_primed;
            if (we) begin
                r_tvld[waddr] <= 1'b1;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (fire) begin
            r_o_value <= i_item.sensor_ok ? n_value[s] : '0;
            r_o_err   <= i_item.sensor_ok && n_err[s];
            r_o_sent  <= sent;
            r_o_armed <= i_item.sensor_ok && n_armed[s];
            r_o_att   <= i_item.sensor_ok ? n_att[s] : '0;
            r_tsel    <= tsel;
            r_rd_vld  <= r_tvld[raddr];
        end
    end

    assign o_valid         = r_ov;
    assign o_value         = r_o_value;
    assign o_read_error    = r_o_err;
    assign o_send_alert    = r_o_sent;
    assign o_alert_armed   = r_o_armed;
    assign o_attempt_count = r_o_att;
    assign o_trend_value   = (r_tsel && r_rd_vld) ? rdata : '0;
endmodule

// ===== rtl/sensor_threshold_alarm_with_trends.sv =====
// an accepted beat waits in the queue, then its result is registered in the back end
// throughput: one beat per cycle while i_stall is low; a two entry queue parts decode from the state update
// the trend store is one ram with a registered read, cleared through per entry valid bits
// reset: synchronous, active low; clears sensor state, config and valid bits, not result data; no clearing pass
// depends on sta_pkg, sta_front, sta_fifo, sta_back, sta_ram
module sensor_threshold_alarm_with_trends import sta_pkg::*; #(
    parameter int SENSORS     = SENSORS_DEF,
    parameter int TREND_DEPTH = TREND_DEPTH_DEF,
    parameter int NOISE_STEP  = NOISE_STEP_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CDAT_W-1:0] i_cfg_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [SENS_W-1:0] i_sensor,
    input  logic [RAW_W-1:0]  i_raw_reading,
    input  logic [HOUR_W-1:0] i_hour,
    input  logic              i_alert_delivered,
    input  logic [SLOT_W-1:0] i_trend_slot,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [VAL_W-1:0]  o_value,
    output logic              o_read_error,
    output logic              o_send_alert,
    output logic              o_alert_armed,
    output logic [CNT_W-1:0]  o_attempt_count,
    output logic [VAL_W-1:0]  o_trend_value
);
    t_item item_in;
    t_item item_q;
    logic  q_full;
    logic  q_valid;
    logic  pop;

    sta_front #(
        .SENSORS     (SENSORS),
        .NOISE_STEP  (NOISE_STEP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_mode            (i_mode),
        .i_sensor          (i_sensor),
        .i_raw_reading     (i_raw_reading),
        .i_hour            (i_hour),
        .i_alert_delivered (i_alert_delivered),
        .i_trend_slot      (i_trend_slot),
        .o_item            (item_in)
    );

    sta_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_data  (item_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (item_q)
    );

    sta_back #(
        .SENSORS     (SENSORS),
        .TREND_DEPTH (TREND_DEPTH),
        .NOISE_STEP  (NOISE_STEP)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_item_valid    (q_valid),
        .i_item          (item_q),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value),
        .o_read_error    (o_read_error),
        .o_send_alert    (o_send_alert),
        .o_alert_armed   (o_alert_armed),
        .o_attempt_count (o_attempt_count),
        .o_trend_value   (o_trend_value)
    );

    assign o_stall = q_full;

    a_sent_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_send_alert && o_read_error))
        else $error("alert sent for a sensor with a bad read");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present right after reset");

    a_pop_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid && (!o_valid || !i_stall))
        else $error("queue popped without an item or output room");
endmodule

// ===== bench/testbench.sv =====
// self-checking bench for sensor_threshold_alarm_with_trends: random and directed beats
// a clocked driver and monitor check each result against an in-bench alarm predictor
// depends on sta_pkg and the rtl of sensor_threshold_alarm_with_trends
`timescale 1ns / 100ps

module testbench;
    import sta_pkg::*;

    localparam int NSENS    = 4;
    localparam int DEPTH    = 24;
    localparam int STEP     = 20;
    localparam int WDOG_MAX = 4000;

    typedef struct {
        t_mode             mode;
        logic [SENS_W-1:0] sensor;
        logic [RAW_W-1:0]  raw;
        logic [HOUR_W-1:0] hour;
        logic              delivered;
        logic [SLOT_W-1:0] slot;
    } t_reading;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             read_error;
        logic             send_alert;
        logic             alert_armed;
        logic [CNT_W-1:0] attempt_count;
        logic [VAL_W-1:0] trend_value;
    } t_alarm_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = '0;
    logic [CDAT_W-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_mode = '0;
    logic [SENS_W-1:0] i_sensor = '0;
    logic [RAW_W-1:0]  i_raw_reading = '0;
    logic [HOUR_W-1:0] i_hour = '0;
    logic              i_alert_delivered = 1'b0;
    logic [SLOT_W-1:0] i_trend_slot = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [VAL_W-1:0]  o_value;
    logic              o_read_error;
    logic              o_send_alert;
    logic              o_alert_armed;
    logic [CNT_W-1:0]  o_attempt_count;
    logic [VAL_W-1:0]  o_trend_value;

    sensor_threshold_alarm_with_trends dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    logic [11:0] trip_q [NSENS];
    logic [7:0]  cond_reg;
    int          hyst_reg, consec_reg, maxatt_reg;
    logic [11:0] value_q [NSENS];
    logic        error_q [NSENS];
    logic [11:0] trend_q [NSENS][DEPTH];
    int          head_q [NSENS];
    logic [4:0]  last_hour_q [NSENS];
    logic        primed;
    logic [7:0]  on_q [NSENS];
    logic [7:0]  off_q [NSENS];
    logic [1:0]  prev_cond_q [NSENS];
    logic        armed_q [NSENS];
    logic [7:0]  attempts_q [NSENS];

    t_reading      pending_q [$];
    t_alarm_status status_q [$];
    t_reading      cur;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            errors = 0;
    int            quiet = 0;
    logic [4:0]    cur_hour = 5'd0;

    function automatic logic [7:0] sat8(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic bit alert_update(int s, bit on, logic [7:0] ct, bit deliv);
        if (int'(ct) < consec_reg) return 0;
        if (!on) begin
            armed_q[s] = 1'b1;
            attempts_q[s] = 8'd0;
            return 0;
        end
        if (!armed_q[s]) return 0;
        armed_q[s] = !deliv;
        attempts_q[s] = armed_q[s] ? sat8(attempts_q[s]) : 8'd0;
        if (int'(attempts_q[s]) >= maxatt_reg) armed_q[s] = 1'b0;
        return 1;
    endfunction

    function automatic bit bound_check(int s, bit deliv);
        logic [1:0] c;
        int v, t;
        c = cond_reg[2*s +: 2];
        v = int'(value_q[s]);
        t = int'(trip_q[s]);
        if (error_q[s]) return 0;
        if (c == COND_RSVD) c = COND_NONE;
        if (c != prev_cond_q[s]) begin
            on_q[s] = 8'd0;
            off_q[s] = 8'd0;
            prev_cond_q[s] = c;
        end
        if ((c == COND_LT && v < t) || (c == COND_GT && v > t)) begin
            on_q[s] = sat8(on_q[s]);
            off_q[s] = 8'd0;
            return alert_update(s, 1, on_q[s], deliv);
        end
        if ((c == COND_LT && v >= t + hyst_reg) || (c == COND_GT && v <= t - hyst_reg)) begin
            on_q[s] = 8'd0;
            off_q[s] = sat8(off_q[s]);
            return alert_update(s, 0, off_q[s], deliv);
        end
        return 0;
    endfunction

    function automatic t_alarm_status apply_reading(t_reading b);
        t_alarm_status r;
        int s, rv, q;
        bit sent;
        logic [11:0] tv;
        s = int'(b.sensor);
        sent = 0;
        tv = 12'd0;
        case (b.mode)
            MODE_SAMPLE: begin
                rv = int'($signed(b.raw));
                if (rv == -1) begin
                    error_q[s] = 1'b1;
                end else begin
                    error_q[s] = 1'b0;
                    if (rv > 4095) rv = 4095;
                    q = (rv > STEP) ? (rv / STEP) * STEP : 0;
                    value_q[s] = q[11:0];
                    if (!primed) begin
                        foreach (last_hour_q[i]) last_hour_q[i] = b.hour;
                        primed = 1'b1;
                    end
                    if (b.hour != last_hour_q[s]) begin
                        head_q[s] = (head_q[s] == 0) ? DEPTH - 1 : head_q[s] - 1;
                        trend_q[s][head_q[s]] = value_q[s];
                        last_hour_q[s] = b.hour;
                    end
                end
            end
            MODE_CHECK: sent = bound_check(s, b.delivered);
            MODE_READ: if (int'(b.slot) < DEPTH)
                tv = trend_q[s][(head_q[s] + int'(b.slot)) % DEPTH];
            default: ;
        endcase
        r.value = value_q[s];
        r.read_error = error_q[s];
        r.send_alert = sent;
        r.alert_armed = armed_q[s];
        r.attempt_count = attempts_q[s];
        r.trend_value = tv;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) status_q.push_back(apply_reading(cur));
            if (!i_valid || !o_stall) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= cur.mode;
                    i_sensor <= cur.sensor;
                    i_raw_reading <= cur.raw;
                    i_hour <= cur.hour;
                    i_alert_delivered <= cur.delivered;
                    i_trend_slot <= cur.slot;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report(string name, int exp_v, int act_v);
        $display("%0t: %s mismatch expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_alarm_status e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result beat, value %0d", $time, o_value);
                    errors++;
                end else begin
                    e = status_q.pop_front();
                    if (o_value !== e.value) report("value", int'(e.value), int'(o_value));
                    if (o_read_error !== e.read_error)
                        report("read_error", int'(e.read_error), int'(o_read_error));
                    if (o_send_alert !== e.send_alert)
                        report("send_alert", int'(e.send_alert), int'(o_send_alert));
                    if (o_alert_armed !== e.alert_armed)
                        report("alert_armed", int'(e.alert_armed), int'(o_alert_armed));
                    if (o_attempt_count !== e.attempt_count)
                        report("attempt_count", int'(e.attempt_count),
                               int'(o_attempt_count));
                    if (o_trend_value !== e.trend_value)
                        report("trend_value", int'(e.trend_value), int'(o_trend_value));
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)
            || (pending_q.size() == 0 && status_q.size() == 0 && !i_valid))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg idx, int data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[CDAT_W-1:0];
        case (idx)
            CFG_TRIP0, CFG_TRIP1, CFG_TRIP2, CFG_TRIP3: trip_q[int'(idx)] = data[11:0];
            CFG_COND:   cond_reg = data[7:0];
            CFG_HYST:   hyst_reg = int'(data[11:0]);
            CFG_CONSEC: consec_reg = int'(data[7:0]);
            CFG_MAXATT: maxatt_reg = int'(data[7:0]);
            default: ;
        endcase
    endtask

    task automatic configure(int t0, int t1, int t2, int t3, int c, int h, int n, int m);
        write_reg(CFG_TRIP0, t0);
        write_reg(CFG_TRIP1, t1);
        write_reg(CFG_TRIP2, t2);
        write_reg(CFG_TRIP3, t3);
        write_reg(CFG_COND, c);
        write_reg(CFG_HYST, h);
        write_reg(CFG_CONSEC, n);
        write_reg(CFG_MAXATT, m);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add(t_mode md, int s, int raw, int hr, bit d, int slot);
        t_reading b;
        b.mode = md;
        b.sensor = s[1:0];
        b.raw = raw[RAW_W-1:0];
        b.hour = hr[4:0];
        b.delivered = d;
        b.slot = slot[4:0];
        pending_q.push_back(b);
    endtask

    task automatic add_random(int n);
        int s, r, sel;
        for (int k = 0; k < n; k++) begin
            s = $urandom_range(NSENS - 1);
            sel = $urandom_range(99);
            if ($urandom_range(4) == 0)
                cur_hour = (cur_hour == 5'd23) ? 5'd0 : cur_hour + 5'd1;
            r = $urandom_range(9);
            if (r == 0) r = -1;
            else if (r == 1) r = int'($signed(13'($urandom)));
            else r = int'(trip_q[s]) + $urandom_range(300) - 150;
            if (r > 4095) r = 4095;
            if (sel < 40)
                add(MODE_SAMPLE, s, r,
                    ($urandom_range(19) == 0) ? $urandom_range(31) : int'(cur_hour),
                    $urandom_range(1), $urandom_range(31));
            else if (sel < 80)
                add(MODE_CHECK, s, $urandom, $urandom, $urandom_range(3) == 0, $urandom);
            else if (sel < 95)
                add(MODE_READ, s, $urandom, $urandom, $urandom_range(1), $urandom_range(31));
            else
                add(MODE_IDLE, s, $urandom, $urandom, $urandom_range(1), $urandom_range(31));
        end
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !i_valid && status_q.size() == 0);
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        foreach (trip_q[i]) trip_q[i] = 12'd0;
        cond_reg = 8'd0;
        hyst_reg = 50;
        consec_reg = 5;
        maxatt_reg = 5;
        primed = 1'b0;
        foreach (value_q[i]) begin
            value_q[i] = 12'd0;
            error_q[i] = 1'b0;
            head_q[i] = 0;
            last_hour_q[i] = 5'd0;
            on_q[i] = 8'd0;
            off_q[i] = 8'd0;
            prev_cond_q[i] = COND_NONE;
            armed_q[i] = 1'b1;
            attempts_q[i] = 8'd0;
            foreach (trend_q[i][j]) trend_q[i][j] = 12'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with reset registers, then a small config
        add(MODE_READ, 0, 0, 0, 0, 0);
        add(MODE_CHECK, 0, 0, 0, 1, 0);
        add(MODE_SAMPLE, 0, 4095, 7, 0, 0);
        add(MODE_SAMPLE, 1, -1, 8, 0, 0);
        add(MODE_CHECK, 1, 0, 0, 0, 0);
        add(MODE_SAMPLE, 2, 20, 8, 0, 0);
        add(MODE_SAMPLE, 2, 21, 9, 0, 0);
        add(MODE_SAMPLE, 3, -4096, 23, 0, 0);
        add(MODE_SAMPLE, 3, -2, 0, 0, 0);
        add(MODE_READ, 3, 0, 0, 0, 0);
        add(MODE_READ, 3, 0, 0, 0, 23);
        add(MODE_READ, 3, 0, 0, 0, 31);
        add(MODE_IDLE, 2, 0, 0, 1, 0);
        drain();
        configure(100, 100, 4095, 0, 8'hC9, 0, 1, 2);
        add(MODE_SAMPLE, 0, 60, 1, 0, 0);
        add(MODE_CHECK, 0, 0, 0, 0, 0);
        add(MODE_CHECK, 0, 0, 0, 0, 0);
        add(MODE_CHECK, 0, 0, 0, 1, 0);
        add(MODE_SAMPLE, 0, 200, 2, 0, 0);
        add(MODE_CHECK, 0, 0, 0, 0, 0);
        add(MODE_SAMPLE, 1, 300, 3, 0, 0);
        add(MODE_CHECK, 1, 0, 0, 1, 0);
        add(MODE_CHECK, 1, 0, 0, 0, 0);
        add(MODE_CHECK, 3, 0, 0, 0, 0);
        add(MODE_CHECK, 2, 0, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0)
                configure(0, 0, 0, 0, 0, 0, 1, 1);
            else if (ph == 1)
                configure(4095, 4095, 4095, 4095, 255, 4095, 255, 255);
            else
                configure($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                          $urandom_range(4095), $urandom_range(255), $urandom_range(200),
                          $urandom_range(1, 6), $urandom_range(1, 6));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            add_random(200);
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sta_pkg.sv
rtl/sta_ram.sv
rtl/sta_front.sv
rtl/sta_fifo.sv
rtl/sta_back.sv
rtl/sensor_threshold_alarm_with_trends.sv
bench/testbench.sv
